### rtl/lfb_pkg.sv
// ----------------------------------------------------------------------------
// lfb_pkg
// Shared types, codes and tables for the LED fade and breathing controller.
// ----------------------------------------------------------------------------
package lfb_pkg;

	localparam int LVL_W   = 7;
	localparam int MS_W    = 16;
	localparam int PCT_W   = 8;
	localparam int OP_W    = 3;
	localparam int PROD_W  = LVL_W + MS_W;
	localparam int IDX_W   = 3;

	localparam logic [LVL_W-1:0] LVL_MAX        = 7'd100;
	localparam logic [MS_W-1:0]  BREATH_MIN_MS  = 16'd100;
	localparam logic [31:0]      ROUND_HALF     = 32'd32767;
	localparam logic [16:0]      CMP_DIV        = 17'd65535;
	localparam logic [16:0]      CMP_DIV2       = 17'd131070;

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_SET    = 3'd1;
	localparam logic [OP_W-1:0] OP_BREATH = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
	localparam logic [OP_W-1:0] OP_CANCEL = 3'd4;

	localparam logic CFG_FADE = 1'b0;
	localparam logic CFG_TOP  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_TMUL,
		ST_TWAIT,
		ST_GMUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [MS_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [LVL_W-1:0] quot;
	} div_rsp_t;

	localparam logic [15:0] GAMMA_TAB [0:100] = '{
		16'd0, 16'd3, 16'd12, 16'd29, 16'd55, 16'd90, 16'd134, 16'd189, 16'd253,
		16'd328, 16'd413, 16'd510, 16'd618, 16'd736, 16'd867, 16'd1009, 16'd1163,
		16'd1329, 16'd1507, 16'd1697, 16'd1900, 16'd2115, 16'd2343, 16'd2584,
		16'd2838, 16'd3104, 16'd3384, 16'd3677, 16'd3983, 16'd4303, 16'd4636,
		16'd4983, 16'd5343, 16'd5717, 16'd6106, 16'd6508, 16'd6924, 16'd7354,
		16'd7798, 16'd8257, 16'd8730, 16'd9217, 16'd9719, 16'd10235, 16'd10766,
		16'd11312, 16'd11872, 16'd12448, 16'd13038, 16'd13643, 16'd14263,
		16'd14898, 16'd15548, 16'd16214, 16'd16894, 16'd17590, 16'd18302,
		16'd19028, 16'd19770, 16'd20528, 16'd21301, 16'd22090, 16'd22895,
		16'd23715, 16'd24551, 16'd25403, 16'd26271, 16'd27154, 16'd28054,
		16'd28970, 16'd29901, 16'd30849, 16'd31813, 16'd32793, 16'd33790,
		16'd34802, 16'd35831, 16'd36877, 16'd37939, 16'd39017, 16'd40112,
		16'd41223, 16'd42351, 16'd43496, 16'd44657, 16'd45835, 16'd47029,
		16'd48241, 16'd49469, 16'd50714, 16'd51976, 16'd53255, 16'd54551,
		16'd55864, 16'd57195, 16'd58542, 16'd59906, 16'd61287, 16'd62686,
		16'd64102, 16'd65535
	};

	function automatic logic [15:0] gamma_lut(input logic [LVL_W-1:0] pct);
		logic [LVL_W-1:0] p;
		p = (pct > LVL_MAX) ? LVL_MAX : pct;
		return GAMMA_TAB[p];
	endfunction

endpackage

### rtl/lfb_div.sv
// ----------------------------------------------------------------------------
// lfb_div
// Shift-subtract divider, one quotient bit per cycle, quotient below 128.
// ----------------------------------------------------------------------------
module lfb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lfb_pkg::div_req_t req,
	output lfb_pkg::div_rsp_t rsp
);

	logic [lfb_pkg::PROD_W-1:0] rem_q;
	logic [lfb_pkg::MS_W-1:0]   den_q;
	logic [lfb_pkg::IDX_W-1:0]  cnt_q;
	logic [lfb_pkg::LVL_W-1:0]  quot_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lfb_pkg::PROD_W-1:0] trial;

	assign trial = {{lfb_pkg::LVL_W{1'b0}}, den_q} << cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= lfb_pkg::IDX_W'(lfb_pkg::LVL_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			den_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q && rem_q >= trial) begin
			rem_q         <= rem_q - trial;
			quot_q[cnt_q] <= 1'b1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### rtl/led_fade_breath_controller_unit.sv
// ----------------------------------------------------------------------------
// led_fade_breath_controller_unit
// LED fade and breathing controller with gamma-2.2 PWM compare output.
// ----------------------------------------------------------------------------
// Takes one command word at a time and returns one result word per command.
// A command with no fade arithmetic passes through the evaluate, gamma
// multiply and done states; a tick that advances a running fade also runs
// the 7-step shift-subtract divider that forms the interpolated level.
// The input is accepted while a previous result still waits on the master
// side. Configuration writes are taken at any time and should only be made
// while the block is idle.
module led_fade_breath_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] opcode, [18:3] tick_ms, [26:19] percent, [31:27] zero
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] current_level, [13:7] target_level, [14] is_breathing,
	// [15] accepted, [31:16] compare_value
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LW = lfb_pkg::LVL_W;
	localparam int MW = lfb_pkg::MS_W;

	lfb_pkg::state_t state_q, state_nx;

	logic [MW-1:0] fade_q, top_q;
	logic [LW-1:0] now_q, goal_q, from_q, saved_q;
	logic          breath_q;
	logic [MW-1:0] len_q, elap_q;

	logic [lfb_pkg::OP_W-1:0]  op_q;
	logic [MW-1:0]             ms_q;
	logic [lfb_pkg::PCT_W-1:0] pct_q;

	logic [LW-1:0] diff_q;
	logic          desc_q;
	logic          ok_q;
	logic [31:0]   gprod_q;
	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;

	// evaluation results
	logic [LW-1:0] n_now, n_goal, n_from, n_saved, n_diff;
	logic          n_breath, n_ok, n_need, n_desc;
	logic [MW-1:0] n_len, n_elap;

	logic              accept, load_out, div_fin;
	lfb_pkg::div_req_t div_req;
	lfb_pkg::div_rsp_t div_rsp;
	logic [LW-1:0]     fade_lvl;

	logic [15:0] cmp_q0;
	logic [16:0] cmp_r, cmp_q;
	logic [15:0] cmp_val;

	lfb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;

	always_comb begin
		logic [MW:0]   sum;
		logic [LW-1:0] tgt;
		n_now    = now_q;
		n_goal   = goal_q;
		n_from   = from_q;
		n_saved  = saved_q;
		n_breath = breath_q;
		n_len    = len_q;
		n_elap   = elap_q;
		n_ok     = 1'b1;
		n_need   = 1'b0;
		n_diff   = '0;
		n_desc   = 1'b0;
		sum      = '0;
		tgt      = '0;
		unique case (op_q)
			lfb_pkg::OP_TICK: begin
				if (now_q != goal_q || breath_q) begin
					if (now_q == goal_q) begin
						tgt    = (goal_q == lfb_pkg::LVL_MAX) ? '0 : lfb_pkg::LVL_MAX;
						n_from = now_q;
						n_goal = tgt;
						n_len  = fade_q;
						n_elap = '0;
						if (fade_q == '0) n_now = tgt;
						if (fade_q < lfb_pkg::BREATH_MIN_MS) n_len = lfb_pkg::BREATH_MIN_MS;
					end
					if (n_len == '0) begin
						n_now = n_goal;
					end else begin
						sum    = {1'b0, n_elap} + {1'b0, ms_q};
						n_elap = (sum > {1'b0, n_len}) ? n_len : sum[MW-1:0];
						n_need = 1'b1;
						n_desc = n_goal < n_from;
						n_diff = n_desc ? (n_from - n_goal) : (n_goal - n_from);
					end
				end
			end
			lfb_pkg::OP_SET: begin
				if (breath_q || pct_q > {1'b0, lfb_pkg::LVL_MAX}) begin
					n_ok = 1'b0;
				end else begin
					n_from = now_q;
					n_goal = pct_q[LW-1:0];
					n_len  = fade_q;
					n_elap = '0;
					if (fade_q == '0) n_now = pct_q[LW-1:0];
				end
			end
			lfb_pkg::OP_BREATH: begin
				if (!breath_q) begin
					n_saved  = goal_q;
					n_breath = 1'b1;
					n_from   = now_q;
					n_goal   = lfb_pkg::LVL_MAX;
					n_len    = (fade_q < lfb_pkg::BREATH_MIN_MS) ? lfb_pkg::BREATH_MIN_MS : fade_q;
					n_elap   = '0;
					if (fade_q == '0) n_now = lfb_pkg::LVL_MAX;
				end
			end
			lfb_pkg::OP_STOP: begin
				if (breath_q) begin
					n_breath = 1'b0;
					n_from   = now_q;
					n_goal   = saved_q;
					n_len    = fade_q;
					n_elap   = '0;
					if (fade_q == '0) n_now = saved_q;
				end
			end
			lfb_pkg::OP_CANCEL: begin
				n_breath = 1'b0;
				n_now    = '0;
				n_goal   = '0;
				n_from   = '0;
				n_elap   = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lfb_pkg::ST_IDLE:  if (s_tvalid) state_nx = lfb_pkg::ST_EVAL;
			lfb_pkg::ST_EVAL:  state_nx = n_need ? lfb_pkg::ST_TMUL : lfb_pkg::ST_GMUL;
			lfb_pkg::ST_TMUL:  state_nx = lfb_pkg::ST_TWAIT;
			lfb_pkg::ST_TWAIT: if (div_rsp.done) state_nx = lfb_pkg::ST_GMUL;
			lfb_pkg::ST_GMUL:  state_nx = lfb_pkg::ST_DONE;
			lfb_pkg::ST_DONE:  if (!m_tvalid_q || m_tready) state_nx = lfb_pkg::ST_IDLE;
			default:           state_nx = lfb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = (state_q == lfb_pkg::ST_IDLE);
		div_req.start    = (state_q == lfb_pkg::ST_TMUL);
		div_req.dividend = lfb_pkg::PROD_W'(diff_q * elap_q);
		div_req.divisor  = len_q;
		div_fin          = (state_q == lfb_pkg::ST_TWAIT) && div_rsp.done;
		load_out         = (state_q == lfb_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	end

	assign accept   = s_tvalid && s_tready;
	assign fade_lvl = desc_q ? (from_q - div_rsp.quot) : (from_q + div_rsp.quot);

	// x / 65535 as (x >> 16) plus up to two corrections
	assign cmp_q0  = gprod_q[31:16];
	assign cmp_r   = {1'b0, gprod_q[15:0]} + {1'b0, cmp_q0};
	assign cmp_q   = {1'b0, cmp_q0} + 17'(cmp_r >= lfb_pkg::CMP_DIV)
	                 + 17'(cmp_r >= lfb_pkg::CMP_DIV2);
	assign cmp_val = cmp_q[16] ? 16'hFFFF : cmp_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lfb_pkg::ST_IDLE;
			fade_q     <= '0;
			top_q      <= 16'hFFFF;
			now_q      <= '0;
			goal_q     <= '0;
			from_q     <= '0;
			saved_q    <= '0;
			breath_q   <= 1'b0;
			len_q      <= '0;
			elap_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					lfb_pkg::CFG_FADE: fade_q <= cfg_data;
					lfb_pkg::CFG_TOP:  top_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == lfb_pkg::ST_EVAL) begin
				now_q    <= n_now;
				goal_q   <= n_goal;
				from_q   <= n_from;
				saved_q  <= n_saved;
				breath_q <= n_breath;
				len_q    <= n_len;
				elap_q   <= n_elap;
			end
			if (div_fin) now_q <= fade_lvl;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tdata[2:0];
			ms_q  <= s_tdata[18:3];
			pct_q <= s_tdata[26:19];
		end
		if (state_q == lfb_pkg::ST_EVAL) begin
			diff_q <= n_diff;
			desc_q <= n_desc;
			ok_q   <= n_ok;
		end
		if (state_q == lfb_pkg::ST_GMUL)
			gprod_q <= 32'(lfb_pkg::gamma_lut(now_q) * ({1'b0, top_q} + 17'd1))
			           + lfb_pkg::ROUND_HALF;
		if (load_out)
			m_tdata_q <= {cmp_val, ok_q, breath_q, goal_q, now_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
